>>> rtl/core/aesd_pkg.sv
// aesd_pkg: types, byte tables and round functions for the aes-128 decrypt core
// no dependencies; used by every module in rtl/core
package aesd_pkg;

	localparam int NumRounds = 10;
	localparam int AddrWidth = 4;
	localparam logic RegKeyLow = 1'b0;
	localparam logic RegKeyHigh = 1'b1;

	typedef struct packed {
		logic [63:0] cipher_high;
		logic [63:0] cipher_low;
	} blk_in_t;

	typedef struct packed {
		logic [63:0] plain_high;
		logic [63:0] plain_low;
	} blk_out_t;

	typedef struct packed {
		logic        en;
		logic        sel;
		logic [63:0] data;
	} key_wr_t;

	localparam logic [0:255][7:0] SBOX = {
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [0:255][7:0] INV_SBOX = {
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	function automatic logic [7:0] xt(input logic [7:0] a);
		xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
		logic [7:0] a2, a4, a8;
		a2 = xt(a);
		a4 = xt(a2);
		a8 = xt(a4);
		gmul = (b[0] ? a : 8'h00) ^ (b[1] ? a2 : 8'h00) ^ (b[2] ? a4 : 8'h00)
			^ (b[3] ? a8 : 8'h00);
	endfunction

	function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
		logic [127:0] t;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[8*(r+4*c) +: 8] = INV_SBOX[s[8*(r+4*((c-r+4)%4)) +: 8]];
			end
		end
		inv_shift_sub = t;
	endfunction

	function automatic logic [127:0] inv_mix(input logic [127:0] s);
		logic [127:0] t;
		logic [7:0] a0, a1, a2, a3;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			a0 = s[32*c +: 8];
			a1 = s[32*c+8 +: 8];
			a2 = s[32*c+16 +: 8];
			a3 = s[32*c+24 +: 8];
			t[32*c +: 8]    = gmul(a0, 4'd14) ^ gmul(a1, 4'd11) ^ gmul(a2, 4'd13) ^ gmul(a3, 4'd9);
			t[32*c+8 +: 8]  = gmul(a0, 4'd9) ^ gmul(a1, 4'd14) ^ gmul(a2, 4'd11) ^ gmul(a3, 4'd13);
			t[32*c+16 +: 8] = gmul(a0, 4'd13) ^ gmul(a1, 4'd9) ^ gmul(a2, 4'd14) ^ gmul(a3, 4'd11);
			t[32*c+24 +: 8] = gmul(a0, 4'd11) ^ gmul(a1, 4'd13) ^ gmul(a2, 4'd9) ^ gmul(a3, 4'd14);
		end
		inv_mix = t;
	endfunction

	function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
		logic [31:0] t, w0, w1, w2, w3;
		t = {SBOX[k[103:96]], SBOX[k[127:120]], SBOX[k[119:112]], SBOX[k[111:104]] ^ rc};
		w0 = k[31:0] ^ t;
		w1 = k[63:32] ^ w0;
		w2 = k[95:64] ^ w1;
		w3 = k[127:96] ^ w2;
		key_step = {w3, w2, w1, w0};
	endfunction

endpackage

>>> rtl/core/aes128_block_decrypt.sv
// aes128_block_decrypt: pipelined aes-128 block decryption with apb key port
// depends on aesd_pkg, aesd_key_exp, aesd_round
//
// channel | handshake          | payload
// input   | start, busy        | cipher
// output  | done               | plain
// config  | psel/penable/pwrite| paddr, pwdata, prdata
//
// an item goes in every cycle while busy is low; done rises when its result leaves the last round stage
// one register stage per round, plus the first key add stage
// after reset or a key write, busy stays high while the round keys are built
// the receiver cannot stall; done marks plain for one cycle
module aes128_block_decrypt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  aesd_pkg::blk_in_t             cipher,
	output logic                          done,
	output aesd_pkg::blk_out_t            plain,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [aesd_pkg::AddrWidth-1:0] paddr,
	input  logic [63:0]                   pwdata,
	output logic [63:0]                   prdata,
	output logic                          pready
);
	import aesd_pkg::*;

	key_wr_t            wr;
	logic [63:0]        key_low, key_high;
	logic               expanding;
	logic [10:0][127:0] rkeys;
	logic               vld_s1;
	logic [127:0]       data_s1;
	logic [NumRounds:0]        vld_r;
	logic [NumRounds:0][127:0] data_r;

	assign pready = 1'b1;
	assign wr.en   = psel & penable & pwrite & (paddr[2:0] == 3'd0);
	assign wr.sel  = paddr[3];
	assign wr.data = pwdata;
	assign prdata  = (paddr[3] == RegKeyHigh) ? key_high : key_low;

	aesd_key_exp u_key (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.key_low   (key_low),
		.key_high  (key_high),
		.expanding (expanding),
		.rkeys     (rkeys)
	);

	assign busy = expanding;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else vld_s1 <= start & ~busy;
	end

	always_ff @(posedge clk) begin
		if (start & ~busy) data_s1 <= {cipher.cipher_high, cipher.cipher_low} ^ rkeys[NumRounds];
	end

	assign vld_r[0]  = vld_s1;
	assign data_r[0] = data_s1;

	for (genvar i = 0; i < NumRounds; i++) begin : g_round
		aesd_round #(
			.LastRound (i == NumRounds - 1)
		) u_round (
			.clk     (clk),
			.arst_n  (arst_n),
			.vld_in  (vld_r[i]),
			.data_in (data_r[i]),
			.rkey    (rkeys[NumRounds-1-i]),
			.vld_s1  (vld_r[i+1]),
			.data_s1 (data_r[i+1])
		);
	end

	assign done  = vld_r[NumRounds];
	assign plain = data_r[NumRounds];
endmodule

>>> rtl/core/aesd_key_exp.sv
// aesd_key_exp: key registers and iterative round key schedule, one round key a cycle
// depends on aesd_pkg
module aesd_key_exp (
	input  logic                clk,
	input  logic                arst_n,
	input  aesd_pkg::key_wr_t   wr,
	output logic [63:0]         key_low,
	output logic [63:0]         key_high,
	output logic                expanding,
	output logic [10:0][127:0]  rkeys
);
	import aesd_pkg::*;

	logic [63:0]  key_low_q, key_high_q;
	logic         load_q, run_q;
	logic [3:0]   cnt_q;
	logic [127:0] cur_q, nxt;
	logic [7:0]   rc;
	logic [10:0][127:0] rk_q;

	always_comb begin
		case (cnt_q)
			4'd1:    rc = 8'h01;
			4'd2:    rc = 8'h02;
			4'd3:    rc = 8'h04;
			4'd4:    rc = 8'h08;
			4'd5:    rc = 8'h10;
			4'd6:    rc = 8'h20;
			4'd7:    rc = 8'h40;
			4'd8:    rc = 8'h80;
			4'd9:    rc = 8'h1b;
			4'd10:   rc = 8'h36;
			default: rc = 8'h00;
		endcase
	end

	assign nxt = key_step(cur_q, rc);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
			load_q     <= 1'b1;
			run_q      <= 1'b0;
			cnt_q      <= '0;
		end else begin
			if (wr.en) begin
				if (wr.sel == RegKeyHigh) key_high_q <= wr.data;
				else key_low_q <= wr.data;
			end
			load_q <= wr.en;
			if (load_q) begin
				run_q <= 1'b1;
				cnt_q <= 4'd1;
			end else if (run_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'(NumRounds)) run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_q) begin
			cur_q    <= {key_high_q, key_low_q};
			rk_q[0]  <= {key_high_q, key_low_q};
		end else if (run_q) begin
			cur_q        <= nxt;
			rk_q[cnt_q]  <= nxt;
		end
	end

	assign key_low   = key_low_q;
	assign key_high  = key_high_q;
	assign expanding = load_q | run_q;
	assign rkeys     = rk_q;
endmodule

>>> rtl/core/aesd_round.sv
// aesd_round: one registered inverse cipher round
// depends on aesd_pkg
module aesd_round #(
	parameter bit LastRound = 1'b0
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         vld_in,
	input  logic [127:0] data_in,
	input  logic [127:0] rkey,
	output logic         vld_s1,
	output logic [127:0] data_s1
);
	import aesd_pkg::*;

	logic [127:0] keyed, res;

	assign keyed = inv_shift_sub(data_in) ^ rkey;
	assign res   = LastRound ? keyed : inv_mix(keyed);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else vld_s1 <= vld_in;
	end

	always_ff @(posedge clk) begin
		if (vld_in) data_s1 <= res;
	end
endmodule

>>> test/aes128_block_decrypt_test.sv
// aes128_block_decrypt_test: self-checking bench for the aes-128 decrypt core
// depends on aesd_pkg and aes128_block_decrypt; predicts each plaintext from its own
// key schedule and inverse cipher, loads keys over apb, and checks results in order
`timescale 1ns / 1ps

module aes128_block_decrypt_test;
	import aesd_pkg::*;

	localparam int IdleLimit = 3000;
	localparam int DrainCycles = 20;
	localparam logic [AddrWidth-1:0] AddrKeyLow = AddrWidth'(8 * RegKeyLow);
	localparam logic [AddrWidth-1:0] AddrKeyHigh = AddrWidth'(8 * RegKeyHigh);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	blk_in_t cipher = '0;
	logic done;
	blk_out_t plain;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [AddrWidth-1:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;

	logic [7:0] sub_fwd [256];
	logic [7:0] sub_inv [256];
	logic [63:0] key_lo_q, key_hi_q;
	logic [127:0] round_keys [11];
	blk_out_t plain_q [$];
	int errors = 0;
	int idle_cycles = 0;

	aes128_block_decrypt dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cipher(cipher),
		.done(done), .plain(plain), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #1 clk = ~clk;

	function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		p = '0;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) p ^= a;
			a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
		end
		return p;
	endfunction

	function automatic void build_sub_tables();
		logic [7:0] r, b, s;
		for (int x = 0; x < 256; x++) begin
			r = 8'h01;
			b = x[7:0];
			for (int i = 0; i < 8; i++) begin
				if ((254 >> i) & 1) r = gf_times(r, b);
				b = gf_times(b, b);
			end
			s = r ^ {r[6:0], r[7]} ^ {r[5:0], r[7:6]} ^ {r[4:0], r[7:5]} ^ {r[3:0], r[7:4]}
				^ 8'h63;
			sub_fwd[x] = s;
			sub_inv[s] = x[7:0];
		end
	endfunction

	function automatic void expand_round_keys();
		logic [7:0] w [176];
		logic [7:0] t [4];
		logic [7:0] rc, t0;
		rc = 8'h01;
		for (int i = 0; i < 8; i++) begin
			w[i] = key_lo_q[8*i +: 8];
			w[8+i] = key_hi_q[8*i +: 8];
		end
		for (int i = 4; i < 44; i++) begin
			for (int k = 0; k < 4; k++) t[k] = w[(i-1)*4+k];
			if (i % 4 == 0) begin
				t0 = t[0];
				t[0] = sub_fwd[t[1]] ^ rc;
				t[1] = sub_fwd[t[2]];
				t[2] = sub_fwd[t[3]];
				t[3] = sub_fwd[t0];
				rc = gf_times(rc, 8'h02);
			end
			for (int k = 0; k < 4; k++) w[i*4+k] = w[(i-4)*4+k] ^ t[k];
		end
		for (int r = 0; r < 11; r++)
			for (int k = 0; k < 16; k++) round_keys[r][8*k +: 8] = w[r*16+k];
	endfunction

	function automatic logic [127:0] unshift_unsub(input logic [127:0] s);
		logic [127:0] t;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				t[8*(r+4*c) +: 8] = sub_inv[s[8*(r+4*((c-r+4)%4)) +: 8]];
		return t;
	endfunction

	function automatic logic [127:0] unmix_columns(input logic [127:0] s);
		logic [127:0] t;
		logic [7:0] a [4];
		logic [7:0] m [4];
		m = '{8'd14, 8'd11, 8'd13, 8'd9};
		for (int c = 0; c < 4; c++) begin
			for (int k = 0; k < 4; k++) a[k] = s[32*c+8*k +: 8];
			for (int r = 0; r < 4; r++) begin
				t[32*c+8*r +: 8] = '0;
				for (int k = 0; k < 4; k++)
					t[32*c+8*r +: 8] ^= gf_times(a[k], m[(k-r+4)%4]);
			end
		end
		return t;
	endfunction

	function automatic blk_out_t decrypt_block(input blk_in_t blk);
		logic [127:0] s;
		s = {blk.cipher_high, blk.cipher_low} ^ round_keys[10];
		for (int r = 9; r > 0; r--)
			s = unmix_columns(unshift_unsub(s) ^ round_keys[r]);
		s = unshift_unsub(s) ^ round_keys[0];
		return '{plain_high: s[127:64], plain_low: s[63:0]};
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_block(input blk_in_t blk, input int gap);
		start <= 1'b1;
		cipher <= blk;
		do @(posedge clk); while (busy);
		plain_q.push_back(decrypt_block(blk));
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		if (start) begin
			start <= 1'b0;
			@(posedge clk);
		end
		while (plain_q.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_key(input logic [AddrWidth-1:0] addr, input logic [63:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == AddrKeyLow) key_lo_q = value;
		else key_hi_q = value;
		expand_round_keys();
		@(posedge clk);
	endtask

	task automatic set_key(input logic [63:0] lo, input logic [63:0] hi);
		wait_idle();
		write_key(AddrKeyLow, lo);
		write_key(AddrKeyHigh, hi);
	endtask

	function automatic blk_in_t rand_block();
		return '{cipher_high: {$urandom, $urandom}, cipher_low: {$urandom, $urandom}};
	endfunction

	task automatic test_reset_key();
		send_block('{cipher_high: '0, cipher_low: '0}, 0);
		send_block('{cipher_high: '1, cipher_low: '1}, 1);
		send_block('{cipher_high: 64'h0123_4567_89ab_cdef, cipher_low: 64'hfedc_ba98_7654_3210}, 0);
		for (int i = 0; i < 4; i++) send_block(rand_block(), 0);
	endtask

	task automatic test_known_vector();
		set_key(64'h0706_0504_0302_0100, 64'h0f0e_0d0c_0b0a_0908);
		send_block('{cipher_high: 64'h5ac5_b470_80b7_cdd8, cipher_low: 64'h3004_7b6a_d8e0_c469}, 2);
		send_block('{cipher_high: '0, cipher_low: '1}, 0);
		send_block('{cipher_high: '1, cipher_low: '0}, 0);
	endtask

	task automatic test_extreme_keys();
		set_key('1, '1);
		send_block('{cipher_high: '0, cipher_low: '0}, 0);
		send_block('{cipher_high: '1, cipher_low: '1}, 3);
		set_key('0, '1);
		send_block(rand_block(), 0);
		send_block('{cipher_high: '0, cipher_low: '0}, 0);
		// a single register write must re-expand the whole schedule
		wait_idle();
		write_key(AddrKeyLow, 64'h8000_0000_0000_0001);
		send_block(rand_block(), 0);
		send_block('{cipher_high: '1, cipher_low: '1}, 0);
		wait_idle();
		write_key(AddrKeyHigh, 64'h0000_0001_8000_0000);
		send_block(rand_block(), 0);
		send_block(rand_block(), 1);
	endtask

	task automatic test_random_keys();
		int burst;
		for (int phase = 0; phase < 14; phase++) begin
			set_key({$urandom, $urandom}, {$urandom, $urandom});
			burst = (phase % 4 == 3);
			for (int i = 0; i < 120; i++) send_block(rand_block(), burst ? 0 : pick_gap());
		end
	endtask

	always @(posedge clk) begin
		blk_out_t want;
		if (arst_n && done) begin
			if (plain_q.size() == 0) begin
				$display("%0t: unexpected plaintext %h", $time, plain);
				errors++;
			end else begin
				want = plain_q.pop_front();
				if (plain.plain_low !== want.plain_low) begin
					$display("%0t: plain_low expected %h actual %h", $time, want.plain_low,
						plain.plain_low);
					errors++;
				end
				if (plain.plain_high !== want.plain_high) begin
					$display("%0t: plain_high expected %h actual %h", $time, want.plain_high,
						plain.plain_high);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || !arst_n) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		build_sub_tables();
		key_lo_q = '0;
		key_hi_q = '0;
		expand_round_keys();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_key();
		test_known_vector();
		test_extreme_keys();
		test_random_keys();
		wait_idle();
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
